@@ sv/isfp_pkg.sv @@
// Package for the IMU serial frame parser: request structs, protocol bytes,
// frame kind codes and the fixed-point scaling constants.
// No dependencies.
`default_nettype none

package isfp_pkg;

  // Protocol bytes
  localparam logic [7:0] HDR_BYTE = 8'h55;
  localparam logic [7:0] TYPE_ACC = 8'h51;
  localparam logic [7:0] TYPE_GYR = 8'h52;
  localparam logic [7:0] TYPE_ANG = 8'h53;

  // Frame kind codes as reported on the result
  localparam logic [1:0] KIND_ACC = 2'd0;
  localparam logic [1:0] KIND_GYR = 2'd1;
  localparam logic [1:0] KIND_ANG = 2'd2;

  // Scaling: scaled = (mag * SCALE_COEF + SCALE_OFS) >> SCALE_SHIFT.
  // Acceleration 49/40 uses a reciprocal of 40 (exact for every 16-bit
  // magnitude); the other two are exact binary fractions. Offsets fold in
  // the half for round-to-nearest.
  localparam int unsigned SCALE_SHIFT = 27;
  localparam int unsigned COEF_W      = 31;
  localparam logic [COEF_W-1:0] COEF_ACC = 31'd164416756;   // 49 * ceil(2^27/40)
  localparam logic [COEF_W-1:0] COEF_GYR = 31'd2097152000;  // 125 * 2^24
  localparam logic [COEF_W-1:0] COEF_ANG = 31'd188743680;   // 45 * 2^22
  localparam logic [COEF_W-1:0] OFS_ACC  = 31'd67108880;    // 20 * ceil(2^27/40)
  localparam logic [COEF_W-1:0] OFS_BIN  = 31'd67108864;    // half an LSB, 2^26

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          frame_kind;
    logic signed [15:0]  raw_x;
    logic signed [15:0]  raw_y;
    logic signed [15:0]  raw_z;
    logic signed [19:0]  scaled_x;
    logic signed [19:0]  scaled_y;
    logic signed [19:0]  scaled_z;
  } out_item_t;

endpackage

`default_nettype wire

@@ sv/imu_serial_frame_parser.sv @@
// IMU serial frame parser top level: input register, frame state machine,
// payload store, three axis scalers and the result register.
// Depends on isfp_pkg and isfp_axis_scale.
`default_nettype none

// Takes one received byte per request and emits one result per good frame
// (header 0x55, type 0x51/0x52/0x53, PAYLOAD_BYTES payload bytes, 8-bit sum
// checksum). One byte is accepted every clock cycle while the result side
// keeps up; a result is registered once its checksum byte is processed
// from the input register. The byte held in the input register is parsed and, on the
// checksum byte, the three axes are scaled by one constant multiply each
// straight into the result register, so that multiply sets the cycle time.
// A held result only stalls the input once the input register is full as
// well. Bad frames and unknown type bytes are dropped without a result;
// end_of_buffer sends the parser back to hunting after that byte. No
// clearing pass after reset: payload bytes are always written before use.
module imu_serial_frame_parser import isfp_pkg::*; #(
  parameter int unsigned PAYLOAD_BYTES = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned IDX_W = $clog2(PAYLOAD_BYTES);
  localparam int unsigned POS_W = $clog2(PAYLOAD_BYTES + 1);

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_TYPE = 3'd1;
  localparam logic [2:0] PH_ACC  = 3'd2;
  localparam logic [2:0] PH_GYR  = 3'd3;
  localparam logic [2:0] PH_ANG  = 3'd4;

  logic             in_valid_q;
  in_item_t         in_q;
  logic [2:0]       phase_q, phase_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       store_q [PAYLOAD_BYTES];
  logic             out_valid_q;
  out_item_t        out_q;

  logic        out_free;
  logic        proc;
  logic        store_we;
  logic        good;
  logic [1:0]  kind;
  out_item_t   result;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign proc       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_item_i;
    end
  end

  // Frame state machine
  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    sum_d    = sum_q;
    store_we = 1'b0;
    good     = 1'b0;
    case (phase_q)
      PH_HUNT: begin
        if (in_q.rx_byte == HDR_BYTE) begin
          sum_d   = HDR_BYTE;
          pos_d   = '0;
          phase_d = PH_TYPE;
        end
      end
      PH_TYPE: begin
        pos_d = '0;
        if (in_q.rx_byte inside {TYPE_ACC, TYPE_GYR, TYPE_ANG}) begin
          sum_d = sum_q + in_q.rx_byte;
          case (in_q.rx_byte)
            TYPE_GYR: phase_d = PH_GYR;
            TYPE_ANG: phase_d = PH_ANG;
            default:  phase_d = PH_ACC;
          endcase
        end else begin
          sum_d   = '0;
          phase_d = PH_HUNT;
        end
      end
      PH_ACC, PH_GYR, PH_ANG: begin
        if (pos_q < POS_W'(PAYLOAD_BYTES)) begin
          store_we = 1'b1;
          sum_d    = sum_q + in_q.rx_byte;
          pos_d    = pos_q + POS_W'(1);
        end else begin
          // Checksum byte: compare, then hunt again either way
          good    = (in_q.rx_byte == sum_q);
          phase_d = PH_HUNT;
          pos_d   = '0;
          sum_d   = '0;
        end
      end
      default: begin
        phase_d = PH_HUNT;
        pos_d   = '0;
        sum_d   = '0;
      end
    endcase
    if (in_q.end_of_buffer) begin
      phase_d = PH_HUNT;
      pos_d   = '0;
      sum_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      pos_q   <= '0;
      sum_q   <= '0;
    end else if (proc) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      sum_q   <= sum_d;
    end
  end

  // Payload store
  always_ff @(posedge clk_i) begin
    if (proc && store_we) begin
      store_q[pos_q[IDX_W-1:0]] <= in_q.rx_byte;
    end
  end

  always_comb begin
    case (phase_q)
      PH_GYR:  kind = KIND_GYR;
      PH_ANG:  kind = KIND_ANG;
      default: kind = KIND_ACC;
    endcase
  end

  assign result.frame_kind = kind;
  assign result.raw_x      = signed'({store_q[1], store_q[0]});
  assign result.raw_y      = signed'({store_q[3], store_q[2]});
  assign result.raw_z      = signed'({store_q[5], store_q[4]});

  isfp_axis_scale u_scale_x (
    .raw_i    (result.raw_x),
    .kind_i   (kind),
    .scaled_o (result.scaled_x)
  );

  isfp_axis_scale u_scale_y (
    .raw_i    (result.raw_y),
    .kind_i   (kind),
    .scaled_o (result.scaled_y)
  );

  isfp_axis_scale u_scale_z (
    .raw_i    (result.raw_z),
    .kind_i   (kind),
    .scaled_o (result.scaled_z)
  );

  // Result register: hold while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= proc && good;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && good) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

@@ sv/isfp_axis_scale.sv @@
// Axis scaler: converts one raw signed axis sample to units of 1/256 for
// the given frame kind, rounding half away from zero. Uses isfp_pkg.
`default_nettype none

module isfp_axis_scale import isfp_pkg::*; (
  input  logic signed [15:0] raw_i,
  input  logic [1:0]         kind_i,
  output logic signed [19:0] scaled_o
);

  localparam int unsigned PROD_W = 16 + COEF_W;

  logic              neg;
  logic [15:0]       mag;
  logic [COEF_W-1:0] coef;
  logic [COEF_W-1:0] ofs;
  logic [PROD_W-1:0] prod;
  logic [19:0]       quot;

  // Work on the magnitude so rounding is symmetric about zero
  assign neg = raw_i[15];
  assign mag = neg ? (16'(~raw_i) + 16'd1) : raw_i;

  always_comb begin
    case (kind_i)
      KIND_GYR: begin
        coef = COEF_GYR;
        ofs  = OFS_BIN;
      end
      KIND_ANG: begin
        coef = COEF_ANG;
        ofs  = OFS_BIN;
      end
      default: begin
        coef = COEF_ACC;
        ofs  = OFS_ACC;
      end
    endcase
  end

  assign prod     = PROD_W'(mag) * PROD_W'(coef) + PROD_W'(ofs);
  assign quot     = prod[SCALE_SHIFT +: 20];
  assign scaled_o = neg ? signed'(20'd0 - quot) : signed'(quot);

endmodule

`default_nettype wire

@@ sv/isfp_checker.sv @@
// Port-level checker for the IMU serial frame parser, bound to the top
// level. Depends on isfp_pkg.
`default_nettype none

module isfp_checker import isfp_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // A stalled request holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_item_i))
    else $error("stalled request changed");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // Input backpressure only comes from a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  a_kind_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.frame_kind == KIND_ACC) ||
                    (out_item_o.frame_kind == KIND_GYR) ||
                    (out_item_o.frame_kind == KIND_ANG))
    else $error("frame kind out of range");

  // Every scale factor exceeds one, so the sign carries through
  a_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.raw_x[15] == out_item_o.scaled_x[19]) &&
                    (out_item_o.raw_y[15] == out_item_o.scaled_y[19]) &&
                    (out_item_o.raw_z[15] == out_item_o.scaled_z[19]))
    else $error("scaled axis sign differs from raw axis");

endmodule

bind imu_serial_frame_parser isfp_checker u_isfp_checker (.*);

`default_nettype wire
